/* rtl/core/sprc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the semiprime range counter.
// No dependencies; every other file of the block imports this package.
package sprc_pkg;

  localparam int SPRC_FIELD_W   = 17;
  localparam int SPRC_MAX_LIMIT = 65536;

  typedef logic [SPRC_FIELD_W-1:0] sprc_field_t;

  localparam sprc_field_t SPRC_LIMIT_RESET = sprc_field_t'(65536);
  localparam sprc_field_t SPRC_COUNT_MAX   = '1;

endpackage

/* rtl/core/sprc_builder.sv */
`timescale 1ns / 1ps
// Table builder: sieve, semiprime marking and prefix count stream.
// Depends on sprc_pkg; feeds the prefix table write port of sprc_query.
module sprc_builder #(
  parameter int MAX_LIMIT = sprc_pkg::SPRC_MAX_LIMIT,
  localparam int AW = $clog2(MAX_LIMIT + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [AW-1:0] lim,
  output logic          tables_ready,
  output logic          pf_we,
  output logic [AW-1:0] pf_addr,
  output logic [AW-1:0] pf_data
);
  import sprc_pkg::*;

  localparam int NW = AW + 1;

  localparam logic [3:0] ST_INIT     = 4'd0;
  localparam logic [3:0] ST_SV_CHK   = 4'd1;
  localparam logic [3:0] ST_SV_TEST  = 4'd2;
  localparam logic [3:0] ST_SV_CROSS = 4'd3;
  localparam logic [3:0] ST_SM_CHK   = 4'd4;
  localparam logic [3:0] ST_SM_TEST  = 4'd5;
  localparam logic [3:0] ST_SM_RD    = 4'd6;
  localparam logic [3:0] ST_SM_MARK  = 4'd7;
  localparam logic [3:0] ST_PF       = 4'd8;
  localparam logic [3:0] ST_DONE     = 4'd9;

  logic [3:0]    state;
  logic [NW-1:0] k;
  logic [AW-1:0] i;
  logic [NW-1:0] sq;
  logic [NW-1:0] j;
  logic [AW-1:0] q;
  logic [AW-1:0] run;
  logic          pf_v;
  logic [AW-1:0] pf_addr_r;

  logic prime_mem [0:MAX_LIMIT];
  logic semi_mem  [0:MAX_LIMIT];
  logic prime_rd;
  logic semi_rd;

  logic [NW-1:0] lim_x;
  logic [NW-1:0] sq_next;
  logic [AW-1:0] i_next;
  logic [AW-1:0] run_next;
  logic [AW-1:0] prime_raddr;
  logic          prime_we;
  logic [AW-1:0] prime_waddr;
  logic          prime_wdata;
  logic          semi_we;
  logic [AW-1:0] semi_waddr;
  logic          semi_wdata;

  assign lim_x    = {1'b0, lim};
  // (i+1)^2 = i^2 + 2i + 1
  assign sq_next  = sq + {i, 1'b1};
  assign i_next   = i + AW'(1);
  assign run_next = run + AW'(semi_rd);

  always_comb begin
    case (state)
      ST_SM_RD: prime_raddr = q;
      default:  prime_raddr = i;
    endcase
  end

  always_comb begin
    prime_we    = 1'b0;
    prime_waddr = k[AW-1:0];
    prime_wdata = 1'b0;
    semi_we     = 1'b0;
    semi_waddr  = k[AW-1:0];
    semi_wdata  = 1'b0;
    case (state)
      ST_INIT: begin
        prime_we    = (k <= lim_x);
        prime_wdata = (k >= NW'(2));
        semi_we     = (k <= lim_x);
      end
      ST_SV_CROSS: begin
        prime_we    = (j <= lim_x);
        prime_waddr = j[AW-1:0];
      end
      ST_SM_MARK: begin
        semi_we    = prime_rd;
        semi_waddr = j[AW-1:0];
        semi_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (prime_we) begin
      prime_mem[prime_waddr] <= prime_wdata;
    end
    prime_rd <= prime_mem[prime_raddr];
  end

  always_ff @(posedge clk) begin
    if (semi_we) begin
      semi_mem[semi_waddr] <= semi_wdata;
    end
    semi_rd <= semi_mem[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      state        <= ST_INIT;
      k            <= '0;
      pf_v         <= 1'b0;
      tables_ready <= 1'b0;
    end else begin
      pf_v <= (state == ST_PF) && (k <= lim_x);
      case (state)
        ST_INIT: begin
          if (k > lim_x) begin
            i     <= AW'(2);
            sq    <= NW'(4);
            state <= ST_SV_CHK;
          end else begin
            k <= k + NW'(1);
          end
        end
        ST_SV_CHK: begin
          if (sq > lim_x) begin
            i     <= AW'(2);
            sq    <= NW'(4);
            state <= ST_SM_CHK;
          end else begin
            state <= ST_SV_TEST;
          end
        end
        ST_SV_TEST: begin
          if (prime_rd) begin
            j     <= sq;
            state <= ST_SV_CROSS;
          end else begin
            i     <= i_next;
            sq    <= sq_next;
            state <= ST_SV_CHK;
          end
        end
        ST_SV_CROSS: begin
          if (j > lim_x) begin
            i     <= i_next;
            sq    <= sq_next;
            state <= ST_SV_CHK;
          end else begin
            j <= j + NW'(i);
          end
        end
        ST_SM_CHK: begin
          if (sq > lim_x) begin
            k     <= '0;
            run   <= '0;
            state <= ST_PF;
          end else begin
            state <= ST_SM_TEST;
          end
        end
        ST_SM_TEST: begin
          if (prime_rd) begin
            q     <= i;
            j     <= sq;
            state <= ST_SM_RD;
          end else begin
            i     <= i_next;
            sq    <= sq_next;
            state <= ST_SM_CHK;
          end
        end
        ST_SM_RD: begin
          if (j > lim_x) begin
            i     <= i_next;
            sq    <= sq_next;
            state <= ST_SM_CHK;
          end else begin
            state <= ST_SM_MARK;
          end
        end
        ST_SM_MARK: begin
          q     <= q + AW'(1);
          j     <= j + NW'(i);
          state <= ST_SM_RD;
        end
        ST_PF: begin
          if (pf_v) begin
            run <= run_next;
          end
          if (k <= lim_x) begin
            pf_addr_r <= k[AW-1:0];
            k         <= k + NW'(1);
          end else if (!pf_v) begin
            tables_ready <= 1'b1;
            state        <= ST_DONE;
          end
        end
        ST_DONE: begin
        end
        default: begin
          state <= ST_INIT;
          k     <= '0;
        end
      endcase
    end
  end

  assign pf_we   = pf_v;
  assign pf_addr = pf_addr_r;
  assign pf_data = run_next;

endmodule

/* rtl/core/sprc_query.sv */
`timescale 1ns / 1ps
// Query pipeline: prefix count table with two read ports and three stages.
// Depends on sprc_pkg; table contents come from sprc_builder.
module sprc_query #(
  parameter int MAX_LIMIT = sprc_pkg::SPRC_MAX_LIMIT,
  localparam int AW = $clog2(MAX_LIMIT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tables_ready,
  input  logic [AW-1:0]       lim,
  input  logic                pf_we,
  input  logic [AW-1:0]       pf_addr,
  input  logic [AW-1:0]       pf_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  sprc_pkg::sprc_field_t range_low,
  input  sprc_pkg::sprc_field_t range_high,
  output logic                out_valid,
  input  logic                out_ready,
  output sprc_pkg::sprc_field_t semiprime_count,
  output logic                range_error
);
  import sprc_pkg::*;

  localparam int XW = (AW > SPRC_FIELD_W) ? AW : SPRC_FIELD_W;

  logic [AW-1:0] prefix_mem [0:MAX_LIMIT];

  logic        a_v;
  sprc_field_t a_lo;
  sprc_field_t a_hi;
  logic          b_v;
  logic          b_err;
  logic [AW-1:0] rd_hi;
  logic [AW-1:0] rd_lo;
  logic        c_v;
  logic        c_err;
  sprc_field_t c_count;

  logic          a_ready;
  logic          b_ready;
  logic          c_ready;
  logic          load_a;
  logic          load_b;
  logic          load_c;
  logic          err_next;
  logic [AW-1:0] hi_addr;
  logic [AW-1:0] lo_addr;
  sprc_field_t   lo_dec;
  logic [AW-1:0] diff;
  logic [XW-1:0] diff_x;
  sprc_field_t   count_next;

  assign c_ready  = !c_v || out_ready;
  assign b_ready  = !b_v || c_ready;
  assign a_ready  = !a_v || b_ready;
  assign in_ready = tables_ready && a_ready;
  assign load_a   = in_valid && in_ready;
  assign load_b   = a_v && b_ready;
  assign load_c   = b_v && c_ready;

  assign err_next = (a_lo == '0) || (a_lo > a_hi) || (XW'(a_hi) > XW'(lim));
  assign lo_dec   = a_lo - sprc_field_t'(1);
  assign hi_addr  = AW'(a_hi);
  assign lo_addr  = AW'(lo_dec);

  assign diff       = rd_hi - rd_lo;
  assign diff_x     = XW'(diff);
  assign count_next = b_err ? '0 :
                      (diff_x > XW'(SPRC_COUNT_MAX)) ? SPRC_COUNT_MAX :
                      diff_x[SPRC_FIELD_W-1:0];

  always_ff @(posedge clk) begin
    if (pf_we) begin
      prefix_mem[pf_addr] <= pf_data;
    end
    if (load_b) begin
      rd_hi <= prefix_mem[hi_addr];
      rd_lo <= prefix_mem[lo_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (load_a) begin
      a_lo <= range_low;
      a_hi <= range_high;
    end
    if (load_b) begin
      b_err <= err_next;
    end
    if (load_c) begin
      c_count <= count_next;
      c_err   <= b_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
    end else begin
      if (a_ready) begin
        a_v <= load_a;
      end
      if (b_ready) begin
        b_v <= load_b;
      end
      if (c_ready) begin
        c_v <= load_c;
      end
    end
  end

  assign out_valid       = c_v;
  assign semiprime_count = c_count;
  assign range_error     = c_err;

endmodule

/* rtl/core/semiprime_range_counter.sv */
`timescale 1ns / 1ps
// A query accepted on in_valid/in_ready passes stage A (captures the range), stage B
// (reads both prefix entries) and stage C (subtracts) before it is on the outputs.
// Throughput: one query per cycle once built, while out_ready does not stall the output.
// Reset (synchronous, active high) and every limit write start a table build;
// in_ready is low until it ends. The limit register is always writable.
module semiprime_range_counter #(
  parameter int MAX_LIMIT = sprc_pkg::SPRC_MAX_LIMIT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  sprc_pkg::sprc_field_t cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sprc_pkg::sprc_field_t range_low,
  input  sprc_pkg::sprc_field_t range_high,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sprc_pkg::sprc_field_t semiprime_count,
  output logic                  range_error
);
  import sprc_pkg::*;

  localparam int AW = $clog2(MAX_LIMIT + 1);
  localparam int XW = (AW > SPRC_FIELD_W) ? AW : SPRC_FIELD_W;

  sprc_field_t   upper_limit;
  logic          cfg_write;
  logic [XW-1:0] ul_x;
  logic [XW-1:0] lim_x;
  logic [AW-1:0] lim;

  logic          tables_ready;
  logic          pf_we;
  logic [AW-1:0] pf_addr;
  logic [AW-1:0] pf_data;

  // Limit register: take every write, the builder restarts on the same edge.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= SPRC_LIMIT_RESET;
    end else if (cfg_write) begin
      upper_limit <= cfg_data;
    end
  end

  // Clamp the limit into 1..MAX_LIMIT: zero acts as one, anything larger
  // than the table depth acts as the full depth.
  always_comb begin
    ul_x = XW'(upper_limit);
    if (ul_x == '0) begin
      lim_x = XW'(1);
    end else if (ul_x > XW'(MAX_LIMIT)) begin
      lim_x = XW'(MAX_LIMIT);
    end else begin
      lim_x = ul_x;
    end
  end
  assign lim = lim_x[AW-1:0];

  // Builder: sieve into the prime table, mark products of two primes, then
  // stream the running count into the query side's prefix table.
  sprc_builder #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_builder (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .lim          (lim),
    .tables_ready (tables_ready),
    .pf_we        (pf_we),
    .pf_addr      (pf_addr),
    .pf_data      (pf_data)
  );

  // Query pipeline: hold off items until the tables are ready, then answer
  // prefix[high] - prefix[low - 1] (zero with range_error for a bad range) one item per cycle;
  // stalls back up the stages without dropping or repeating an item.
  sprc_query #(
    .MAX_LIMIT (MAX_LIMIT)
  ) u_query (
    .clk             (clk),
    .rst             (rst),
    .tables_ready    (tables_ready),
    .lim             (lim),
    .pf_we           (pf_we),
    .pf_addr         (pf_addr),
    .pf_data         (pf_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .range_low       (range_low),
    .range_high      (range_high),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .semiprime_count (semiprime_count),
    .range_error     (range_error)
  );

endmodule

/* rtl/core/sprc_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for semiprime_range_counter, attached by bind.
// Depends on sprc_pkg and on the top level's port names.
module sprc_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input sprc_pkg::sprc_field_t semiprime_count,
  input logic                  range_error
);
  import sprc_pkg::*;

  // A rejected range always reports a zero count.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_error |-> semiprime_count == '0)
    else $error("range_error with nonzero count");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(semiprime_count) && $stable(range_error))
    else $error("stalled result changed");

  // Reset starts a table build, so no item is taken right after it.
  a_rst_build: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("item taken before tables built after reset");

  // A limit write starts a rebuild.
  a_cfg_build: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("item taken before tables rebuilt after limit write");

endmodule

bind semiprime_range_counter sprc_checker u_sprc_checker (
  .clk             (clk),
  .rst             (rst),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .semiprime_count (semiprime_count),
  .range_error     (range_error)
);
